### rtl/byte_range_header_parser_defines.svh
// Assertion macros for the byte range header parser.
`ifndef BYTE_RANGE_HEADER_PARSER_DEFINES_SVH
`define BYTE_RANGE_HEADER_PARSER_DEFINES_SVH

// Same-cycle implication, clocked on clk, off during reset
`define BRHP_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, clocked on clk, off during reset
`define BRHP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/brhp_pkg.sv
package brhp_pkg;

  // Character and result field widths, and the default offset width
  localparam int CHAR_W              = 8;
  localparam int FIELD_W             = 48;
  localparam int OFFSET_BITS_DEFAULT = 48;

  // Header summary flags handed from the scanner to the evaluator
  typedef struct packed {
    logic ok_pre;        // prefix good and a dash was seen
    logic suffix_form;   // dash came first after the prefix
    logic tail_present;  // something followed the dash
  } sum_flags_t;

endpackage

### rtl/brhp_scan.sv
module brhp_scan import brhp_pkg::*; #(
  parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  input  logic [CHAR_W-1:0]      header_char,
  input  logic                   last_char,
  output logic [OFFSET_BITS-1:0] sum_start,
  output logic [OFFSET_BITS-1:0] sum_tail,
  output sum_flags_t             sum_flags
);

  localparam logic [OFFSET_BITS-1:0] MAX_VAL    = {OFFSET_BITS{1'b1}};
  localparam int                     PREFIX_LEN = 6;
  localparam logic [CHAR_W-1:0]      CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0]      CHAR_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0]      CHAR_DASH  = 8'h2d;

  typedef enum logic [3:0] {
    PH_PREFIX = 4'b0001,
    PH_EMPTY  = 4'b0010,
    PH_START  = 4'b0100,
    PH_TAIL   = 4'b1000
  } phase_t;

  // Expected character of the "bytes=" prefix at a given position
  function automatic logic [CHAR_W-1:0] prefix_char(input logic [2:0] idx);
    logic [CHAR_W-1:0] ch;
    unique case (idx)
      3'd0:    ch = 8'h62;  // b
      3'd1:    ch = 8'h79;  // y
      3'd2:    ch = 8'h74;  // t
      3'd3:    ch = 8'h65;  // e
      3'd4:    ch = 8'h73;  // s
      default: ch = 8'h3d;  // =
    endcase
    return ch;
  endfunction

  // acc * 10 + d, saturating at the offset maximum
  function automatic logic [OFFSET_BITS-1:0] add_digit(input logic [OFFSET_BITS-1:0] acc,
                                                       input logic [3:0] d);
    logic [OFFSET_BITS+3:0] wide;
    wide = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {{OFFSET_BITS{1'b0}}, d};
    if (wide > {4'b0, MAX_VAL}) begin
      return MAX_VAL;
    end
    return wide[OFFSET_BITS-1:0];
  endfunction

  logic [2:0]             prefix_matched, prefix_matched_next;
  phase_t                 phase, phase_next;
  logic [OFFSET_BITS-1:0] start_accum, start_accum_next;
  logic [OFFSET_BITS-1:0] tail_accum, tail_accum_next;
  logic                   start_open, start_open_next;
  logic                   tail_open, tail_open_next;
  logic                   tail_present, tail_present_next;
  logic                   suffix_form, suffix_form_next;
  logic                   header_bad, header_bad_next;

  logic                   is_digit;
  logic [3:0]             digit_val;
  logic [OFFSET_BITS-1:0] acc_sum;

  assign is_digit  = (header_char >= CHAR_ZERO) && (header_char <= CHAR_NINE);
  assign digit_val = is_digit ? 4'(header_char - CHAR_ZERO) : 4'd0;

  // One shared accumulate unit: tail number after the dash, start number before
  assign acc_sum = add_digit((phase == PH_TAIL) ? tail_accum : start_accum, digit_val);

  // Per-character state update
  always_comb begin
    prefix_matched_next = prefix_matched;
    phase_next          = phase;
    start_accum_next    = start_accum;
    tail_accum_next     = tail_accum;
    start_open_next     = start_open;
    tail_open_next      = tail_open;
    tail_present_next   = tail_present;
    suffix_form_next    = suffix_form;
    header_bad_next     = header_bad;
    unique case (phase)
      PH_PREFIX: begin
        if (header_char != prefix_char(prefix_matched)) begin
          header_bad_next = 1'b1;
        end
        prefix_matched_next = 3'(prefix_matched + 3'd1);
        if (prefix_matched == 3'(PREFIX_LEN - 1)) begin
          phase_next = PH_EMPTY;
        end
      end
      PH_EMPTY, PH_START: begin
        if (header_char == CHAR_DASH) begin
          suffix_form_next = (phase == PH_EMPTY);
          phase_next       = PH_TAIL;
        end else begin
          phase_next = PH_START;
          if (start_open && is_digit) begin
            start_accum_next = acc_sum;
          end else begin
            start_open_next = 1'b0;
          end
        end
      end
      PH_TAIL: begin
        tail_present_next = 1'b1;
        if (tail_open && is_digit) begin
          tail_accum_next = acc_sum;
        end else begin
          tail_open_next = 1'b0;
        end
      end
      default: begin
        phase_next = PH_PREFIX;
      end
    endcase
  end

  // Summary of the header including the current character
  assign sum_start              = start_accum_next;
  assign sum_tail               = tail_accum_next;
  assign sum_flags.ok_pre       = !header_bad_next && (phase_next == PH_TAIL);
  assign sum_flags.suffix_form  = suffix_form_next;
  assign sum_flags.tail_present = tail_present_next;

  // State registers; the last character returns everything to reset
  always_ff @(posedge clk) begin
    if (rst || (step && last_char)) begin
      prefix_matched <= '0;
      phase          <= PH_PREFIX;
      start_accum    <= '0;
      tail_accum     <= '0;
      start_open     <= 1'b1;
      tail_open      <= 1'b1;
      tail_present   <= 1'b0;
      suffix_form    <= 1'b0;
      header_bad     <= 1'b0;
    end else if (step) begin
      prefix_matched <= prefix_matched_next;
      phase          <= phase_next;
      start_accum    <= start_accum_next;
      tail_accum     <= tail_accum_next;
      start_open     <= start_open_next;
      tail_open      <= tail_open_next;
      tail_present   <= tail_present_next;
      suffix_form    <= suffix_form_next;
      header_bad     <= header_bad_next;
    end
  end

endmodule

### rtl/brhp_eval.sv
`include "byte_range_header_parser_defines.svh"

module brhp_eval import brhp_pkg::*; #(
  parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  input  logic [OFFSET_BITS-1:0] ld_start,
  input  logic [OFFSET_BITS-1:0] ld_tail,
  input  sum_flags_t             ld_flags,
  input  logic [FIELD_W-1:0]     resource_size,
  output logic                   ready,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   status,
  output logic [FIELD_W-1:0]     first_byte,
  output logic [FIELD_W-1:0]     last_byte
);

  localparam int                 FSW   = (OFFSET_BITS > FIELD_W) ? OFFSET_BITS : FIELD_W;
  localparam logic [FSW-1:0]     MAX_W = FSW'({OFFSET_BITS{1'b1}});

  logic                   s2_valid;
  logic [OFFSET_BITS-1:0] s2_start;
  logic [OFFSET_BITS-1:0] s2_tail;
  logic [OFFSET_BITS-1:0] s2_fs;
  sum_flags_t             s2_flags;
  logic                   s2_go;
  logic                   s2_hold;

  logic [FSW-1:0]         fs_w;
  logic [OFFSET_BITS-1:0] fs_sat;
  logic [OFFSET_BITS-1:0] fs_m1;
  logic                   tail_sel;
  logic                   ok;
  logic [OFFSET_BITS-1:0] first_v;
  logic [OFFSET_BITS-1:0] last_v;
  logic [FSW-1:0]         first_w;
  logic [FSW-1:0]         last_w;

  assign s2_go = !out_valid || !out_stall;
  assign ready = !s2_valid || s2_go;

  // Summary held back by a stalled result
  assign s2_hold = s2_valid && !s2_go;

  // File size saturates at the offset maximum
  assign fs_w   = FSW'(resource_size);
  assign fs_sat = (fs_w > MAX_W) ? MAX_W[OFFSET_BITS-1:0] : fs_w[OFFSET_BITS-1:0];

  // Summary register
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (load) begin
      s2_valid <= 1'b1;
    end else if (s2_go) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s2_start <= ld_start;
      s2_tail  <= ld_tail;
      s2_fs    <= fs_sat;
      s2_flags <= ld_flags;
    end
  end

  // Range checks; start after end only matters when the end comes from the tail
  assign fs_m1    = s2_fs - OFFSET_BITS'(1);
  assign tail_sel = s2_flags.tail_present && (s2_tail < s2_fs);

  always_comb begin
    ok      = s2_flags.ok_pre;
    first_v = '0;
    last_v  = '0;
    if (s2_flags.suffix_form) begin
      if ((s2_tail == '0) || (s2_tail >= s2_fs)) begin
        ok = 1'b0;
      end
      first_v = s2_fs - s2_tail;
      last_v  = fs_m1;
    end else begin
      first_v = s2_start;
      last_v  = tail_sel ? s2_tail : fs_m1;
      if ((s2_start >= s2_fs) || (tail_sel && (s2_start > s2_tail))) begin
        ok = 1'b0;
      end
    end
    if (!ok) begin
      first_v = '0;
      last_v  = '0;
    end
  end

  assign first_w = FSW'(first_v);
  assign last_w  = FSW'(last_v);

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_go) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go && s2_valid) begin
      status     <= !ok;
      first_byte <= first_w[FIELD_W-1:0];
      last_byte  <= last_w[FIELD_W-1:0];
    end
  end

  `BRHP_ASSERT(a_range_order, out_valid && !status, first_byte <= last_byte, "range reversed")
  `BRHP_ASSERT(a_bad_zeroed, out_valid && status, (first_byte | last_byte) == '0, "offsets set")
  `BRHP_ASSERT(a_no_overrun, load, !s2_valid || s2_go, "summary overwritten while held")
  `BRHP_ASSERT_NEXT(a_sum_hold, s2_hold, s2_valid && $stable({s2_start, s2_flags}), "summary moved")

endmodule

### rtl/byte_range_header_parser.sv
// The last character's result passes the input, summary and result registers in order.
// Throughput: one character beat per cycle, the last one waiting for a free summary slot;
// bound by the scanner's saturating times-ten accumulate loop; one result beat per header.
// Reset (rst, synchronous): clears all valids and returns the scanner to the start of a
// header; no clearing pass, the block takes beats in the first cycle after reset.
module byte_range_header_parser import brhp_pkg::*; #(
  parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [CHAR_W-1:0]  header_char,
  input  logic               last_char,
  input  logic [FIELD_W-1:0] resource_size,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               status,
  output logic [FIELD_W-1:0] first_byte,
  output logic [FIELD_W-1:0] last_byte
);

  logic                   s1_valid;
  logic [CHAR_W-1:0]      s1_char;
  logic                   s1_last;
  logic [FIELD_W-1:0]     s1_fs;
  logic                   s1_go;
  logic                   step;
  logic                   in_take;
  logic                   sum_ready;
  logic [OFFSET_BITS-1:0] sum_start;
  logic [OFFSET_BITS-1:0] sum_tail;
  sum_flags_t             sum_flags;

  // Ordinary characters always move on; the last one waits for a free summary slot
  assign s1_go    = !s1_last || sum_ready;
  assign step     = s1_valid && s1_go;
  assign in_stall = s1_valid && !s1_go;
  assign in_take  = in_valid && !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!s1_valid || s1_go) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_char <= header_char;
      s1_last <= last_char;
      s1_fs   <= resource_size;
    end
  end

  brhp_scan #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_scan (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .header_char(s1_char),
    .last_char  (s1_last),
    .sum_start  (sum_start),
    .sum_tail   (sum_tail),
    .sum_flags  (sum_flags)
  );

  brhp_eval #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_eval (
    .clk          (clk),
    .rst          (rst),
    .load         (step && s1_last),
    .ld_start     (sum_start),
    .ld_tail      (sum_tail),
    .ld_flags     (sum_flags),
    .resource_size(s1_fs),
    .ready        (sum_ready),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .first_byte   (first_byte),
    .last_byte    (last_byte)
  );

endmodule

### tb/byte_range_header_parser_tb.sv
module byte_range_header_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import brhp_pkg::*;

  localparam int OFFSET_BITS = OFFSET_BITS_DEFAULT;
  localparam longint unsigned OFFSET_MAX = ~64'd0 >> (64 - OFFSET_BITS);
  localparam int ITEM_TARGET = 800;
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 3000;
  localparam byte unsigned CH_DASH = 8'h2D;
  localparam byte unsigned CH_ZERO = 8'h30;
  localparam byte unsigned CH_NINE = 8'h39;

  typedef enum logic [1:0] {PH_PREFIX, PH_EMPTY, PH_START, PH_TAIL} scan_phase_t;

  typedef struct {
    bit               status;
    bit [FIELD_W-1:0] first_byte;
    bit [FIELD_W-1:0] last_byte;
  } byte_range_t;

  typedef byte unsigned char_q_t[$];

  // Tracks the header being scanned and the ranges still owed by the block
  class range_checker;
    scan_phase_t     phase;
    int unsigned     prefix_count;
    longint unsigned start_acc;
    longint unsigned tail_acc;
    bit              start_open;
    bit              tail_open;
    bit              tail_seen;
    bit              suffix;
    bit              prefix_bad;
    string           prefix_txt = "bytes=";
    byte_range_t     pending_ranges[$];
    int unsigned     errors;

    function new();
      errors = 0;
      clear_header();
    endfunction

    function void clear_header();
      phase        = PH_PREFIX;
      prefix_count = 0;
      start_acc    = 0;
      tail_acc     = 0;
      start_open   = 1'b1;
      tail_open    = 1'b1;
      tail_seen    = 1'b0;
      suffix       = 1'b0;
      prefix_bad   = 1'b0;
    endfunction

    // decimal accumulate, pinned at the offset maximum
    function longint unsigned add_digit(longint unsigned acc, longint unsigned d);
      if (acc > (OFFSET_MAX - d) / 10) return OFFSET_MAX;
      return acc * 10 + d;
    endfunction

    // One accepted character beat; the last one of a header yields a range
    function void take_char(byte unsigned ch, bit is_last, bit [FIELD_W-1:0] fs);
      bit              digit;
      bit              ok;
      longint unsigned d;
      longint unsigned fsv;
      longint unsigned first_off;
      longint unsigned last_off;
      byte_range_t     r;
      digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
      d = digit ? longint'(ch - CH_ZERO) : 0;
      case (phase)
        PH_PREFIX: begin
          if (ch != prefix_txt[prefix_count]) prefix_bad = 1'b1;
          prefix_count++;
          if (prefix_count >= 6) phase = PH_EMPTY;
        end
        PH_EMPTY, PH_START: begin
          if (ch == CH_DASH) begin
            suffix = (phase == PH_EMPTY);
            phase  = PH_TAIL;
          end else begin
            phase = PH_START;
            if (start_open && digit) start_acc = add_digit(start_acc, d);
            else start_open = 1'b0;
          end
        end
        default: begin
          tail_seen = 1'b1;
          if (tail_open && digit) tail_acc = add_digit(tail_acc, d);
          else tail_open = 1'b0;
        end
      endcase
      if (!is_last) return;

      // resolve the range against the file size
      fsv = fs;
      if (fsv > OFFSET_MAX) fsv = OFFSET_MAX;
      ok = !prefix_bad && (phase == PH_TAIL);
      first_off = 0;
      last_off  = 0;
      if (ok) begin
        if (suffix) begin
          if (tail_acc == 0 || tail_acc >= fsv) begin
            ok = 1'b0;
          end else begin
            first_off = fsv - tail_acc;
            last_off  = fsv - 1;
          end
        end else if (start_acc >= fsv) begin
          ok = 1'b0;
        end else begin
          first_off = start_acc;
          last_off  = fsv - 1;
          if (tail_seen && tail_acc < fsv) last_off = tail_acc;
          if (first_off > last_off) ok = 1'b0;
        end
      end
      r.status     = !ok;
      r.first_byte = ok ? first_off[FIELD_W-1:0] : '0;
      r.last_byte  = ok ? last_off[FIELD_W-1:0] : '0;
      pending_ranges.push_back(r);
      clear_header();
    endfunction

    task report(string msg);
      $display("ERROR at %0t: %s", $time, msg);
      errors++;
    endtask

    // One accepted result beat against the oldest owed range
    task match_range(bit status, bit [FIELD_W-1:0] first_byte, bit [FIELD_W-1:0] last_byte);
      byte_range_t e;
      if (pending_ranges.size() == 0) begin
        report("result beat with no header outstanding");
        return;
      end
      e = pending_ranges.pop_front();
      if (status != e.status)
        report($sformatf("status %0d, expected %0d", status, e.status));
      if (first_byte != e.first_byte)
        report($sformatf("first_byte %0d, expected %0d", first_byte, e.first_byte));
      if (last_byte != e.last_byte)
        report($sformatf("last_byte %0d, expected %0d", last_byte, e.last_byte));
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [CHAR_W-1:0]  header_char = '0;
  logic               last_char = 1'b0;
  logic [FIELD_W-1:0] resource_size = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               status;
  logic [FIELD_W-1:0] first_byte;
  logic [FIELD_W-1:0] last_byte;

  range_checker ranges = new();
  int unsigned  send_idle_pct = 34;
  int unsigned  rcv_idle_pct = 80;
  int unsigned  chars_sent = 0;
  int unsigned  quiet_cycles = 0;
  int           idle_phase = 0;
  bit           hold_done = 1'b0;

  byte_range_header_parser #(
    .OFFSET_BITS(OFFSET_BITS)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .header_char  (header_char),
    .last_char    (last_char),
    .resource_size(resource_size),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .first_byte   (first_byte),
    .last_byte    (last_byte)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Monitor both channels; give up if nothing moves for too long
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall)
      ranges.take_char(header_char, last_char, resource_size);
    if (!rst && out_valid && !out_stall)
      ranges.match_range(status, first_byte, last_byte);
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result side: random stall, plus one long hold-off when the no-idle phase opens
  initial begin
    forever begin
      @(posedge clk);
      if (idle_phase == 2 && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= ($urandom_range(99) < rcv_idle_pct);
    end
  end

  function automatic logic [FIELD_W-1:0] rand_field();
    return FIELD_W'({$urandom(), $urandom()});
  endfunction

  function automatic void add_text(ref char_q_t q, input string s);
    foreach (s[i]) q.push_back(s[i]);
  endfunction

  // mostly small files, with the empty file and the largest size now and then
  function automatic longint unsigned pick_size();
    case ($urandom_range(9))
      0:       return 0;
      1:       return OFFSET_MAX;
      2, 3:    return {$urandom(), $urandom()} & OFFSET_MAX;
      default: return $urandom_range(2000);
    endcase
  endfunction

  // offsets clustered round the file boundaries
  function automatic longint unsigned pick_offset(longint unsigned fs);
    case ($urandom_range(7))
      0:       return 0;
      1:       return fs;
      2:       return (fs == 0) ? 0 : fs - 1;
      3:       return OFFSET_MAX;
      default: return {$urandom(), $urandom()} % (fs + 3);
    endcase
  endfunction

  // Mostly well-formed headers with random numbers; the rest broken or noise
  function automatic void make_header(output char_q_t q, output logic [FIELD_W-1:0] fs);
    longint unsigned sz;
    longint unsigned a;
    longint unsigned b;
    int unsigned     cut;
    q  = {};
    sz = pick_size();
    fs = FIELD_W'(sz);
    if ($urandom_range(99) < 75) begin
      add_text(q, "bytes=");
      case ($urandom_range(3))
        0: add_text(q, $sformatf("-%0d", pick_offset(sz)));
        1: add_text(q, $sformatf("%0d-", pick_offset(sz)));
        default: begin
          a = pick_offset(sz);
          b = ($urandom_range(3) == 0) ? pick_offset(sz) : a + $urandom_range(50);
          add_text(q, $sformatf("%0d-%0d", a, b));
        end
      endcase
      if ($urandom_range(9) == 0) q.insert(6, CH_ZERO);
      if ($urandom_range(9) == 0) add_text(q, "99999999999999999");
      if ($urandom_range(9) == 0) q.push_back(8'($urandom_range(255)));
    end else begin
      case ($urandom_range(3))
        0: begin
          add_text(q, "bytes=1-2");
          q[$urandom_range(5)] = 8'($urandom_range(255));
        end
        1: begin
          add_text(q, "bytes=-1");
          cut = $urandom_range(1, q.size());
          while (q.size() > cut) void'(q.pop_back());
        end
        2: begin
          add_text(q, "bytes=");
          repeat ($urandom_range(1, 12)) begin
            if ($urandom_range(1)) q.push_back(8'(CH_ZERO + $urandom_range(9)));
            else if ($urandom_range(3) == 0) q.push_back(CH_DASH);
            else q.push_back(8'($urandom_range(255)));
          end
        end
        default: repeat ($urandom_range(1, 10)) q.push_back(8'($urandom_range(255)));
      endcase
    end
  endfunction

  // Offer one character beat and wait until it is taken
  task automatic send_char(byte unsigned ch, bit is_last, logic [FIELD_W-1:0] fs);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    header_char   <= ch;
    last_char     <= is_last;
    resource_size <= fs;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    chars_sent++;
  endtask

  // file size only counts on the last beat, so the others carry noise there
  task automatic send_header(char_q_t q, logic [FIELD_W-1:0] fs);
    foreach (q[i]) begin
      if (i == q.size() - 1) send_char(q[i], 1'b1, fs);
      else send_char(q[i], 1'b0, rand_field());
    end
  endtask

  task automatic send_text(string s, logic [FIELD_W-1:0] fs);
    char_q_t q;
    add_text(q, s);
    send_header(q, fs);
  endtask

  initial begin
    char_q_t            q;
    logic [FIELD_W-1:0] fs;
    int unsigned        base;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed headers: prefix faults, each rejection, clamping, odd characters
    send_text("x", 100);
    send_text("byt", 100);
    send_text("Bytes=0-1", 100);
    send_text("bytes=", 100);
    send_text("bytes=5", 100);
    send_text("bytes=0-", 1);
    send_text("bytes=-", 10);
    send_text("bytes=-0", 10);
    send_text("bytes=-10", 10);
    send_text("bytes=-5", 100);
    send_text("bytes=10-", 10);
    send_text("bytes=0-", 0);
    send_text("bytes=5-999", 100);
    send_text("bytes=9-3", 100);
    q = {};
    add_text(q, "bytes=1");
    q.push_back(8'h00);
    add_text(q, "-5");
    send_header(q, 100);
    send_text("bytes=+3- 7", 100);
    send_text("bytes=99999999999999999999-", FIELD_W'(OFFSET_MAX));
    send_text("bytes=-99999999999999999999", FIELD_W'(OFFSET_MAX));
    send_text("bytes=0-99999999999999999999", FIELD_W'(OFFSET_MAX));

    // random headers in three idling phases, topping the run up to the item target
    base = chars_sent;
    for (int p = 0; p < 3; p++) begin
      idle_phase = p;
      case (p)
        0: begin send_idle_pct = 34; rcv_idle_pct = 80; end
        1: begin send_idle_pct = 80; rcv_idle_pct = 34; end
        default: begin send_idle_pct = 0; rcv_idle_pct = 0; end
      endcase
      while (chars_sent < base + (p + 1) * (ITEM_TARGET - base) / 3) begin
        make_header(q, fs);
        send_header(q, fs);
      end
    end
    in_valid <= 1'b0;

    // drain, then leave room for any stray result beat
    while (ranges.pending_ranges.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (ranges.errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
